[hdl/wpb_pkg.sv]
// Package for the weighted pose blend block: field widths, frame record type,
// controller and normalizer state types, and the normalizer result bundle.
// No dependencies.
package wpb_pkg;

    // Frames held per set; the sum widths below are sized for this count.
    localparam int MAX_FRAMES = 16;

    localparam int WEIGHT_W = 16;
    localparam int QUAT_W   = 16;
    localparam int TRANS_W  = 32;
    localparam int SCALE_W  = 16;
    localparam int TSUM_W   = 52;
    localparam int SSUM_W   = 37;
    localparam int RSUM_W   = 37;
    localparam int MAG_W    = 36;
    localparam int A_W      = 30;
    localparam int N2_W     = 62;
    localparam int NORM_W   = 32;
    localparam int NUM_W    = 47;
    localparam int QUO_W    = 17;
    localparam int DOT_W    = 34;
    localparam int SHIFT_W  = 4;
    localparam int ROUND_SH = 15;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd32767;

    // One stored frame: weight and the four rotation components (x, y, z, w).
    typedef struct packed {
        logic [WEIGHT_W-1:0]          weight;
        logic [3:0][QUAT_W-1:0]       quat;
    } frame_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_DOT,
        ST_ACC,
        ST_NSTART,
        ST_NORM,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SHIFT,
        NS_SQ,
        NS_SQRT,
        NS_DIV
    } norm_state_t;

    // Result bundle handed from the normalizer to the controller.
    typedef struct packed {
        logic                   done;
        logic [3:0][QUAT_W-1:0] quat;
    } norm_res_t;

endpackage

[hdl/wpb_frame_mem.sv]
// Frame store: synchronous memory of weight and rotation per frame.
// One write port, one read port with registered read data. Uses wpb_pkg.
module wpb_frame_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  wpb_pkg::frame_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output wpb_pkg::frame_t rd_data
);

    wpb_pkg::frame_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/wpb_accum.sv]
// Translation and scale accumulator with rounding and saturation of the sums.
// Products are registered, then added in the next cycle. Uses wpb_pkg.
module wpb_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                clear,
    input  logic [wpb_pkg::WEIGHT_W-1:0]        weight,
    input  logic signed [wpb_pkg::TRANS_W-1:0]  trans [3],
    input  logic signed [wpb_pkg::SCALE_W-1:0]  scale [3],
    output logic signed [wpb_pkg::TRANS_W-1:0]  trans_res [3],
    output logic signed [wpb_pkg::SCALE_W-1:0]  scale_res [3]
);

    localparam int TP_W = wpb_pkg::TRANS_W + 17;
    localparam int SP_W = wpb_pkg::SCALE_W + 17;
    localparam int TR_W = wpb_pkg::TSUM_W - wpb_pkg::ROUND_SH;
    localparam int SR_W = wpb_pkg::SSUM_W - wpb_pkg::ROUND_SH;

    logic signed [TP_W-1:0]             tprod_reg [3];
    logic signed [SP_W-1:0]             sprod_reg [3];
    logic                               pend_reg;
    logic signed [wpb_pkg::TSUM_W-1:0]  tsum_reg [3];
    logic signed [wpb_pkg::SSUM_W-1:0]  ssum_reg [3];
    logic signed [16:0]                 wext;

    assign wext = $signed({1'b0, weight});

    // Product registers for the frame being accepted.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            tprod_reg[c] <= wext * trans[c];
            sprod_reg[c] <= wext * scale[c];
        end
    end

    // Accumulation of the registered products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                tsum_reg[c] <= '0;
                ssum_reg[c] <= '0;
            end
        end
        else if (clear)
        begin
            pend_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                tsum_reg[c] <= '0;
                ssum_reg[c] <= '0;
            end
        end
        else
        begin
            pend_reg <= en;
            if (pend_reg)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    tsum_reg[c] <= tsum_reg[c] + wpb_pkg::TSUM_W'(tprod_reg[c]);
                    ssum_reg[c] <= ssum_reg[c] + wpb_pkg::SSUM_W'(sprod_reg[c]);
                end
            end
        end
    end

    // Round half up to Q16.16 and Q8.8, then saturate.
    always_comb
    begin
        logic signed [wpb_pkg::TSUM_W-1:0] tt;
        logic signed [wpb_pkg::SSUM_W-1:0] st;
        logic signed [TR_W-1:0]            tr;
        logic signed [SR_W-1:0]            sr;
        for (int c = 0; c < 3; c++)
        begin
            tt = tsum_reg[c] + wpb_pkg::TSUM_W'(16384);
            st = ssum_reg[c] + wpb_pkg::SSUM_W'(16384);
            tr = TR_W'(tt >>> wpb_pkg::ROUND_SH);
            sr = SR_W'(st >>> wpb_pkg::ROUND_SH);
            if (tr > TR_W'(64'sd2147483647))
            begin
                trans_res[c] = 32'sh7FFFFFFF;
            end
            else if (tr < -TR_W'(64'sd2147483648))
            begin
                trans_res[c] = 32'sh80000000;
            end
            else
            begin
                trans_res[c] = tr[31:0];
            end
            if (sr > SR_W'(32767))
            begin
                scale_res[c] = 16'sh7FFF;
            end
            else if (sr < -SR_W'(32768))
            begin
                scale_res[c] = 16'sh8000;
            end
            else
            begin
                scale_res[c] = sr[15:0];
            end
        end
    end

endmodule

[hdl/wpb_norm.sv]
// Iterative quaternion normalizer: range shift, sum of squares, bit-pair
// square root and restoring division per component. Uses wpb_pkg.
module wpb_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [wpb_pkg::RSUM_W-1:0]  rsum [4],
    output wpb_pkg::norm_res_t                 res
);

    wpb_pkg::norm_state_t          state_reg, state_next;
    logic [wpb_pkg::MAG_W-1:0]     mag_reg [4];
    logic [3:0]                    neg_reg;
    logic [wpb_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [1:0]                    idx_reg, idx_next;
    logic [4:0]                    k_reg, k_next;
    logic [wpb_pkg::N2_W-1:0]      rem_reg, rem_next;
    logic [wpb_pkg::N2_W-1:0]      root_reg, root_next;
    logic [wpb_pkg::NORM_W-1:0]    nrm_reg, nrm_next;
    logic [wpb_pkg::NUM_W-1:0]     num_reg, num_next;
    logic [wpb_pkg::QUO_W-1:0]     q_reg, q_next;
    logic [wpb_pkg::QUAT_W-1:0]    quat_reg [4];
    logic [wpb_pkg::QUAT_W-1:0]    quat_val;
    logic                          quat_we;
    logic                          ident;
    logic                          done_next;
    logic                          done_reg;
    logic [wpb_pkg::A_W-1:0]       a_sel;
    logic [wpb_pkg::A_W-1:0]       a_nxt;
    logic                          too_big;

    // Shifted magnitudes of the current and the next component.
    assign a_sel = wpb_pkg::A_W'(mag_reg[idx_reg] >> shift_reg);
    assign a_nxt = wpb_pkg::A_W'(mag_reg[idx_reg + 2'd1] >> shift_reg);

    // Any component still at or above 2^30 after the current shift.
    always_comb
    begin
        logic [wpb_pkg::MAG_W-1:0] sh;
        too_big = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            sh = mag_reg[c] >> shift_reg;
            too_big = too_big | (|sh[wpb_pkg::MAG_W-1:wpb_pkg::A_W]);
        end
    end

    // Next state and datapath control.
    always_comb
    begin
        logic [wpb_pkg::N2_W-1:0] bitv;
        logic [wpb_pkg::N2_W-1:0] rb;
        logic [49:0]              ds;
        logic [wpb_pkg::QUO_W-1:0] qf;
        logic [14:0]              qs;
        state_next = state_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        nrm_next   = nrm_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        quat_val   = '0;
        quat_we    = 1'b0;
        ident      = 1'b0;
        done_next  = 1'b0;
        bitv       = '0;
        rb         = '0;
        ds         = '0;
        qf         = '0;
        qs         = '0;
        case (state_reg)
            wpb_pkg::NS_IDLE:
            begin
                if (start)
                begin
                    shift_next = '0;
                    state_next = wpb_pkg::NS_SHIFT;
                end
            end
            wpb_pkg::NS_SHIFT:
            begin
                if (too_big)
                begin
                    shift_next = shift_reg + 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    rem_next   = '0;
                    state_next = wpb_pkg::NS_SQ;
                end
            end
            wpb_pkg::NS_SQ:
            begin
                rem_next = rem_reg + wpb_pkg::N2_W'(a_sel * a_sel);
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    root_next  = '0;
                    k_next     = 5'd30;
                    state_next = wpb_pkg::NS_SQRT;
                end
            end
            wpb_pkg::NS_SQRT:
            begin
                bitv = wpb_pkg::N2_W'(1) << {k_reg, 1'b0};
                rb   = root_reg + bitv;
                if (rem_reg >= rb)
                begin
                    rem_next  = rem_reg - rb;
                    root_next = (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                k_next = k_reg - 5'd1;
                if (k_reg == 5'd0)
                begin
                    nrm_next = root_next[wpb_pkg::NORM_W-1:0];
                    if (root_next == '0)
                    begin
                        ident      = 1'b1;
                        done_next  = 1'b1;
                        state_next = wpb_pkg::NS_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        num_next   = {1'b0, a_sel, 16'b0}
                                     + wpb_pkg::NUM_W'(root_next[wpb_pkg::NORM_W-1:0]);
                        k_next     = 5'd16;
                        q_next     = '0;
                        state_next = wpb_pkg::NS_DIV;
                    end
                end
            end
            wpb_pkg::NS_DIV:
            begin
                ds = 50'({nrm_reg, 1'b0}) << k_reg;
                if (50'(num_reg) >= ds)
                begin
                    num_next = num_reg - wpb_pkg::NUM_W'(ds);
                    q_next   = q_reg | (wpb_pkg::QUO_W'(1) << k_reg);
                end
                k_next = k_reg - 5'd1;
                if (k_reg == 5'd0)
                begin
                    qf = q_next;
                    qs = (qf > wpb_pkg::QUO_W'(32767)) ? 15'h7FFF : qf[14:0];
                    quat_val = neg_reg[idx_reg] ? -{1'b0, qs} : {1'b0, qs};
                    quat_we  = 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        done_next  = 1'b1;
                        state_next = wpb_pkg::NS_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        num_next = {1'b0, a_nxt, 16'b0} + wpb_pkg::NUM_W'(nrm_reg);
                        k_next   = 5'd16;
                        q_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = wpb_pkg::NS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpb_pkg::NS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        nrm_reg   <= nrm_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        if (state_reg == wpb_pkg::NS_IDLE && start)
        begin
            for (int c = 0; c < 4; c++)
            begin
                neg_reg[c] <= rsum[c][wpb_pkg::RSUM_W-1];
                mag_reg[c] <= wpb_pkg::MAG_W'(rsum[c][wpb_pkg::RSUM_W-1] ?
                                              -rsum[c] : rsum[c]);
            end
        end
        if (ident)
        begin
            quat_reg[0] <= '0;
            quat_reg[1] <= '0;
            quat_reg[2] <= '0;
            quat_reg[3] <= wpb_pkg::QUAT_ONE;
        end
        else if (quat_we)
        begin
            quat_reg[idx_reg] <= quat_val;
        end
    end

    assign res.done = done_reg;
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            res.quat[c] = quat_reg[c];
        end
    end

endmodule

[hdl/weighted_pose_blend_top.sv]
// Top level of the weighted pose blend block.
// Depends on wpb_pkg, wpb_frame_mem, wpb_accum and wpb_norm.
//
// Frames are taken one per cycle until the frame marked last_frame; for
// frames within the capacity, weight times translation and weight times
// scale are summed as they arrive, and weight and rotation are written to
// the frame memory; frames beyond the capacity are transferred but neither
// stored nor summed. After the last frame the block stalls its input, reads
// each stored frame back (memory read, dot product against the reference,
// signed accumulate), passes through a final read state and a start state,
// then normalizes the rotation sum in an iterative unit: range shift, sum of
// squares, square root, division per component and handover (the division
// is skipped for a zero-length sum). The result stays on the output until
// transferred, and input resumes after that.
module weighted_pose_blend_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         weight,
    input  logic signed [31:0]  trans_x,
    input  logic signed [31:0]  trans_y,
    input  logic signed [31:0]  trans_z,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  scale_x,
    input  logic signed [15:0]  scale_y,
    input  logic signed [15:0]  scale_z,
    input  logic                last_frame,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_trans_x,
    output logic signed [31:0]  out_trans_y,
    output logic signed [31:0]  out_trans_z,
    output logic signed [15:0]  out_quat_x,
    output logic signed [15:0]  out_quat_y,
    output logic signed [15:0]  out_quat_z,
    output logic signed [15:0]  out_quat_w,
    output logic signed [15:0]  out_scale_x,
    output logic signed [15:0]  out_scale_y,
    output logic signed [15:0]  out_scale_z
);

    localparam int AW = (wpb_pkg::MAX_FRAMES > 1) ? $clog2(wpb_pkg::MAX_FRAMES) : 1;
    localparam int CW = $clog2(wpb_pkg::MAX_FRAMES + 1);

    wpb_pkg::ctl_state_t                state_reg, state_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      idx_reg;
    logic [wpb_pkg::WEIGHT_W-1:0]       refw_reg;
    logic [3:0][wpb_pkg::QUAT_W-1:0]    refq_reg;
    logic signed [wpb_pkg::RSUM_W-1:0]  rsum_reg [4];
    logic                               dneg_reg;
    logic                               out_valid_reg;
    logic signed [31:0]                 otrans_reg [3];
    logic signed [15:0]                 oscale_reg [3];
    logic [3:0][15:0]                   oquat_reg;

    logic                               in_xfer;
    logic                               out_xfer;
    logic                               take;
    logic                               room;
    wpb_pkg::frame_t                    wr_frame;
    wpb_pkg::frame_t                    rd_frame;
    logic signed [31:0]                 trans_in [3];
    logic signed [15:0]                 scale_in [3];
    logic signed [31:0]                 trans_res [3];
    logic signed [15:0]                 scale_res [3];
    wpb_pkg::norm_res_t                 nres;
    logic                               norm_start;

    assign in_stall = (state_reg != wpb_pkg::ST_LOAD);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign room     = (count_reg < CW'(wpb_pkg::MAX_FRAMES));
    assign take     = in_xfer && room;
    assign norm_start = (state_reg == wpb_pkg::ST_NSTART);

    assign wr_frame.weight  = weight;
    assign wr_frame.quat[0] = quat_x;
    assign wr_frame.quat[1] = quat_y;
    assign wr_frame.quat[2] = quat_z;
    assign wr_frame.quat[3] = quat_w;
    assign trans_in[0] = trans_x;
    assign trans_in[1] = trans_y;
    assign trans_in[2] = trans_z;
    assign scale_in[0] = scale_x;
    assign scale_in[1] = scale_y;
    assign scale_in[2] = scale_z;

    wpb_frame_mem #(
        .DEPTH (wpb_pkg::MAX_FRAMES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_frame),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_frame)
    );

    wpb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (take),
        .clear     (out_xfer),
        .weight    (weight),
        .trans     (trans_in),
        .scale     (scale_in),
        .trans_res (trans_res),
        .scale_res (scale_res)
    );

    wpb_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .rsum  (rsum_reg),
        .res   (nres)
    );

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wpb_pkg::ST_LOAD:
            begin
                if (in_xfer && last_frame)
                begin
                    state_next = wpb_pkg::ST_READ;
                end
            end
            wpb_pkg::ST_READ:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = wpb_pkg::ST_NSTART;
                end
                else
                begin
                    state_next = wpb_pkg::ST_DOT;
                end
            end
            wpb_pkg::ST_DOT:
            begin
                state_next = wpb_pkg::ST_ACC;
            end
            wpb_pkg::ST_ACC:
            begin
                state_next = wpb_pkg::ST_READ;
            end
            wpb_pkg::ST_NSTART:
            begin
                state_next = wpb_pkg::ST_NORM;
            end
            wpb_pkg::ST_NORM:
            begin
                if (nres.done)
                begin
                    state_next = wpb_pkg::ST_OUT;
                end
            end
            wpb_pkg::ST_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = wpb_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = wpb_pkg::ST_LOAD;
            end
        endcase
    end

    // Controller state, frame count, reference and rotation sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpb_pkg::ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            refw_reg      <= '0;
            refq_reg      <= '0;
            dneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                rsum_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0 || weight > refw_reg)
                begin
                    refw_reg <= weight;
                    refq_reg <= wr_frame.quat;
                end
            end
            if (state_reg == wpb_pkg::ST_DOT)
            begin
                logic signed [wpb_pkg::DOT_W-1:0] dot;
                dot = '0;
                for (int c = 0; c < 4; c++)
                begin
                    dot = dot + wpb_pkg::DOT_W'($signed(rd_frame.quat[c])
                                                * $signed(refq_reg[c]));
                end
                dneg_reg <= dot[wpb_pkg::DOT_W-1];
            end
            if (state_reg == wpb_pkg::ST_ACC)
            begin
                logic signed [16:0] sw;
                sw = dneg_reg ? -$signed({1'b0, rd_frame.weight})
                              : $signed({1'b0, rd_frame.weight});
                for (int c = 0; c < 4; c++)
                begin
                    rsum_reg[c] <= rsum_reg[c]
                                   + wpb_pkg::RSUM_W'(sw * $signed(rd_frame.quat[c]));
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (nres.done && state_reg == wpb_pkg::ST_NORM)
            begin
                out_valid_reg <= 1'b1;
            end
            if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
                count_reg     <= '0;
                idx_reg       <= '0;
                refw_reg      <= '0;
                refq_reg      <= '0;
                for (int c = 0; c < 4; c++)
                begin
                    rsum_reg[c] <= '0;
                end
            end
        end
    end

    // Result registers, loaded when normalization completes.
    always_ff @(posedge clk)
    begin
        if (nres.done && state_reg == wpb_pkg::ST_NORM)
        begin
            for (int c = 0; c < 3; c++)
            begin
                otrans_reg[c] <= trans_res[c];
                oscale_reg[c] <= scale_res[c];
            end
            oquat_reg <= nres.quat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_trans_x = otrans_reg[0];
    assign out_trans_y = otrans_reg[1];
    assign out_trans_z = otrans_reg[2];
    assign out_scale_x = oscale_reg[0];
    assign out_scale_y = oscale_reg[1];
    assign out_scale_z = oscale_reg[2];
    assign out_quat_x  = oquat_reg[0];
    assign out_quat_y  = oquat_reg[1];
    assign out_quat_z  = oquat_reg[2];
    assign out_quat_w  = oquat_reg[3];

endmodule

[hdl/wpb_checker.sv]
// Port-level checker for the weighted pose blend top level, with its bind.
// Depends only on the top level's ports.
module wpb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               last_frame,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_trans_x,
    input logic signed [15:0] out_quat_x,
    input logic signed [15:0] out_quat_w
);

    // A transfer of the closing frame stops input for the blend pass.
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_frame |=> in_stall)
        else $error("input not stalled after closing frame");

    // No new frame is taken while a result is pending.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // A stalled result stays, and its translation x holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_trans_x))
        else $error("stalled result changed");

    // Normalized components saturate at 32767; x and w must never reach -32768.
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_quat_x != 16'sh8000) && (out_quat_w != 16'sh8000))
        else $error("quaternion component out of range");

endmodule

bind weighted_pose_blend_top wpb_checker u_wpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_frame  (last_frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_trans_x (out_trans_x),
    .out_quat_x  (out_quat_x),
    .out_quat_w  (out_quat_w)
);
